[hw/rtl/lse_pkg.sv]
// Shared types and constants for the LSB stego embed/extract block.
package lse_pkg;

  localparam int unsigned LEN_BITS       = 32;
  localparam int unsigned LEN_IDX_BITS   = $clog2(LEN_BITS);
  localparam int unsigned POS_BITS       = 40;
  localparam int unsigned GRP_BITS       = POS_BITS - 3;
  localparam int unsigned SKIP_BITS      = 16;
  localparam int unsigned CFG_DATA_BITS  = 32;
  localparam int unsigned CFG_IDX_BITS   = 2;
  localparam int unsigned EMB_IDX_BITS   = 5;
  localparam logic [SKIP_BITS-1:0] SKIP_RESET = 16'd24;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE         = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEADER_SKIP  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EMBED_LENGTH = 2'd2;

  typedef enum logic [1:0] {
    KIND_COVER  = 2'd0,
    KIND_MSG    = 2'd1,
    KIND_LENGTH = 2'd2
  } kind_t;

  typedef struct packed {
    logic                     mode;
    logic [SKIP_BITS-1:0]     header_skip;
    logic [CFG_DATA_BITS-1:0] embed_length;
  } cfg_t;

  typedef struct packed {
    logic [POS_BITS-1:0] pos;
    logic [LEN_BITS-1:0] length_shift;
    logic [7:0]          bit_shift;
    logic [7:0]          payload_latch;
  } state_t;

  typedef struct packed {
    logic                     has_result;
    kind_t                    kind;
    logic [7:0]               data_byte;
    logic [CFG_DATA_BITS-1:0] found_length;
    logic                     last_byte;
  } res_t;

endpackage

[hw/rtl/lse_cfg_regs.sv]
// Configuration register bank: mode, header skip and embed length.
module lse_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_en,
  input  logic [lse_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [lse_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output lse_pkg::cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= 1'b0;
      cfg.header_skip  <= lse_pkg::SKIP_RESET;
      cfg.embed_length <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        lse_pkg::CFG_MODE:         cfg.mode <= cfg_data[0];
        lse_pkg::CFG_HEADER_SKIP:  cfg.header_skip <= cfg_data[lse_pkg::SKIP_BITS-1:0];
        lse_pkg::CFG_EMBED_LENGTH: cfg.embed_length <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/lse_step.sv]
// Per-byte step logic: region decode, LSB embed and bit collection.
module lse_step (
  input  lse_pkg::cfg_t    cfg,
  input  logic             frame_start,
  input  logic [7:0]       cover_byte,
  input  logic [7:0]       payload_byte,
  input  lse_pkg::state_t  st,
  output lse_pkg::state_t  st_next,
  output lse_pkg::res_t    res
);

  localparam logic [lse_pkg::POS_BITS-1:0] POS_MAX = {lse_pkg::POS_BITS{1'b1}};

  logic [lse_pkg::POS_BITS-1:0]     pos_cur;
  logic [lse_pkg::LEN_BITS-1:0]     ls_cur;
  logic [lse_pkg::LEN_BITS-1:0]     ls_new;
  logic [7:0]                       bs_cur;
  logic [7:0]                       bs_new;
  logic [lse_pkg::POS_BITS-1:0]     skip_ext;
  logic [lse_pkg::POS_BITS-1:0]     hdr_end;
  logic [lse_pkg::LEN_IDX_BITS-1:0] field_idx;
  logic [lse_pkg::EMB_IDX_BITS-1:0] emb_idx;
  logic [lse_pkg::POS_BITS-1:0]     msg_off;
  logic [lse_pkg::GRP_BITS-1:0]     grp;
  logic [2:0]                       k;
  logic [lse_pkg::LEN_BITS-1:0]     len_masked;
  logic [7:0]                       latch_use;
  logic                             in_msg_emb;
  logic                             in_msg_ext;
  logic                             is_last;

  always_comb begin
    pos_cur    = frame_start ? '0 : st.pos;
    ls_cur     = frame_start ? '0 : st.length_shift;
    bs_cur     = frame_start ? '0 : st.bit_shift;
    skip_ext   = lse_pkg::POS_BITS'(cfg.header_skip);
    hdr_end    = skip_ext + lse_pkg::POS_BITS'(lse_pkg::LEN_BITS);
    field_idx  = lse_pkg::LEN_IDX_BITS'(pos_cur - skip_ext);
    emb_idx    = lse_pkg::EMB_IDX_BITS'(lse_pkg::LEN_BITS - 1)
               - lse_pkg::EMB_IDX_BITS'(field_idx);
    msg_off    = pos_cur - hdr_end;
    grp        = msg_off[lse_pkg::POS_BITS-1:3];
    k          = msg_off[2:0];
    len_masked = cfg.embed_length[lse_pkg::LEN_BITS-1:0];
    latch_use  = (k == 3'd0) ? payload_byte : st.payload_latch;
    ls_new     = {ls_cur[lse_pkg::LEN_BITS-2:0], cover_byte[0]};
    bs_new     = {bs_cur[6:0], cover_byte[0]};
    in_msg_emb = grp < lse_pkg::GRP_BITS'(len_masked);
    in_msg_ext = grp < lse_pkg::GRP_BITS'(ls_cur);
    is_last    = ({1'b0, grp} + (lse_pkg::GRP_BITS + 1)'(1))
               == (lse_pkg::GRP_BITS + 1)'(ls_cur);

    st_next.pos           = (pos_cur == POS_MAX) ? pos_cur : pos_cur + 1'b1;
    st_next.length_shift  = ls_cur;
    st_next.bit_shift     = bs_cur;
    st_next.payload_latch = st.payload_latch;

    res = '0;
    res.kind = lse_pkg::KIND_COVER;

    if (pos_cur < skip_ext) begin
      if (cfg.mode) begin
        res.has_result = 1'b1;
        res.data_byte  = cover_byte;
      end
    end else if (pos_cur < hdr_end) begin
      if (cfg.mode) begin
        res.has_result = 1'b1;
        res.data_byte  = {cover_byte[7:1], cfg.embed_length[emb_idx]};
      end else begin
        st_next.length_shift = ls_new;
        if (field_idx == lse_pkg::LEN_IDX_BITS'(lse_pkg::LEN_BITS - 1)) begin
          res.has_result   = 1'b1;
          res.kind         = lse_pkg::KIND_LENGTH;
          res.found_length = lse_pkg::CFG_DATA_BITS'(ls_new);
        end
      end
    end else begin
      if (cfg.mode) begin
        if (k == 3'd0) begin
          st_next.payload_latch = payload_byte;
        end
        res.has_result = 1'b1;
        res.data_byte  = in_msg_emb ? {cover_byte[7:1], latch_use[3'd7 - k]} : cover_byte;
      end else if (in_msg_ext) begin
        st_next.bit_shift = bs_new;
        if (k == 3'd7) begin
          res.has_result = 1'b1;
          res.kind       = lse_pkg::KIND_MSG;
          res.data_byte  = bs_new;
          res.last_byte  = is_last;
        end
      end
    end
  end

endmodule

[hw/rtl/lsb_stego_embed_extract.sv]
// Top level of the LSB stego embed/extract block.
//
// Cover bytes enter on the input channel (in_valid/in_ready), one request per
// byte, with frame_start on the first byte of each image. Results leave on the
// output channel (out_valid/out_ready): kind 0 is a cover byte (embed mode),
// kind 1 a recovered message byte with last_byte on the final one, kind 2 the
// decoded 32-bit length. Bytes that give no result are absorbed silently.
// A request passes through the input register, then the step logic feeding
// the result register. One byte is accepted every cycle while the receiver
// keeps up; the position counter, collected length and byte shifters update
// as each request leaves the input register. When the receiver stalls, the
// result register holds and the input register fills; in_ready falls only
// once both are occupied. Configuration is written by the user only while
// idle, through cfg_write_en/cfg_index/cfg_data; the block does not enforce
// this. Reset empties both registers, clears position and shifters, and sets
// mode to extract, header skip to 24 and embed length to 0.
module lsb_stego_embed_extract (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [lse_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lse_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              frame_start,
  input  logic [7:0]                        cover_byte,
  input  logic [7:0]                        payload_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        kind,
  output logic [7:0]                        data_byte,
  output logic [31:0]                       found_length,
  output logic                              last_byte
);

  lse_pkg::cfg_t   cfg;
  lse_pkg::state_t st;
  lse_pkg::state_t st_next;
  lse_pkg::res_t   res;
  lse_pkg::res_t   out_res;

  logic       a_valid;
  logic       a_frame_start;
  logic [7:0] a_cover;
  logic [7:0] a_payload;
  logic       a_go;

  lse_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  lse_step u_step (
    .cfg          (cfg),
    .frame_start  (a_frame_start),
    .cover_byte   (a_cover),
    .payload_byte (a_payload),
    .st           (st),
    .st_next      (st_next),
    .res          (res)
  );

  assign a_go     = a_valid && (!out_valid || out_ready);
  assign in_ready = !a_valid || a_go;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_frame_start <= frame_start;
      a_cover       <= cover_byte;
      a_payload     <= payload_byte;
    end
  end

  // running state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (a_go) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_go) begin
      out_valid <= res.has_result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      out_res <= res;
    end
  end

  assign kind         = out_res.kind;
  assign data_byte    = out_res.data_byte;
  assign found_length = out_res.found_length;
  assign last_byte    = out_res.last_byte;

endmodule

[dv/lsb_stego_embed_extract_tb.sv]
// Self-checking testbench for lsb_stego_embed_extract: embed and extract frames against a predictor.
`timescale 1ns / 100ps

module lsb_stego_embed_extract_tb;
  import lse_pkg::*;

  localparam int unsigned MAX_GAP     = 17;
  localparam int unsigned SETTLE      = 6;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [31:0] LEN_MASK    = 32'((64'd1 << LEN_BITS) - 64'd1);

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [31:0] length;
    logic        last;
  } stego_out_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     cfg_write_en;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic                     frame_start;
  logic [7:0]               cover_byte;
  logic [7:0]               payload_byte;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               kind;
  logic [7:0]               data_byte;
  logic [31:0]              found_length;
  logic                     last_byte;

  // register mirror and predictor state
  logic                reg_mode;
  logic [15:0]         reg_skip;
  logic [31:0]         reg_len;
  logic [POS_BITS-1:0] st_pos;
  logic [31:0]         st_len_acc;
  logic [7:0]          st_byte_acc;
  logic [7:0]          st_latch;

  stego_out_t  pending_out[$];
  bit          calm_in;
  bit          calm_out;
  int unsigned n_req;
  int unsigned n_cover;
  int unsigned n_msg_bytes;
  int unsigned n_lengths;
  int unsigned n_err;
  int unsigned cycles;

  lsb_stego_embed_extract dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .frame_start  (frame_start),
    .cover_byte   (cover_byte),
    .payload_byte (payload_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .data_byte    (data_byte),
    .found_length (found_length),
    .last_byte    (last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned pick_gap(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void stego_predict(logic fs, logic [7:0] cov, logic [7:0] pay);
    logic [POS_BITS-1:0] hdr_end;
    logic [POS_BITS-1:0] len_end;
    logic [POS_BITS-1:0] d;
    logic [POS_BITS-1:0] grp;
    logic [2:0]          k;
    int unsigned         i;
    stego_out_t          o;
    bit                  hit;
    if (fs) begin
      st_pos      = '0;
      st_len_acc  = '0;
      st_byte_acc = '0;
    end
    hit     = 1'b0;
    o       = '{KIND_COVER, 8'd0, 32'd0, 1'b0};
    hdr_end = POS_BITS'(reg_skip);
    len_end = hdr_end + POS_BITS'(LEN_BITS);
    if (st_pos < hdr_end) begin
      if (reg_mode) begin
        hit    = 1'b1;
        o.data = cov;
      end
    end else if (st_pos < len_end) begin
      i = 32'(st_pos - hdr_end);
      if (reg_mode) begin
        hit    = 1'b1;
        o.data = {cov[7:1], reg_len[LEN_BITS-1-i]};
      end else begin
        st_len_acc = ((st_len_acc << 1) | 32'(cov[0])) & LEN_MASK;
        if (i == LEN_BITS - 1) begin
          hit      = 1'b1;
          o.kind   = KIND_LENGTH;
          o.length = st_len_acc;
        end
      end
    end else begin
      d   = st_pos - len_end;
      grp = d >> 3;
      k   = d[2:0];
      if (reg_mode) begin
        if (k == 3'd0) st_latch = pay;
        hit    = 1'b1;
        o.data = (grp < POS_BITS'(reg_len & LEN_MASK)) ? {cov[7:1], st_latch[3'd7-k]} : cov;
      end else if (grp < POS_BITS'(st_len_acc)) begin
        st_byte_acc = {st_byte_acc[6:0], cov[0]};
        if (k == 3'd7) begin
          hit    = 1'b1;
          o.kind = KIND_MSG;
          o.data = st_byte_acc;
          o.last = (grp + 1'b1 == POS_BITS'(st_len_acc));
        end
      end
    end
    if (hit) pending_out.push_back(o);
    if (st_pos != '1) st_pos = st_pos + 1'b1;
  endfunction

  // mirror register writes, predict on each accepted request, check each result
  always @(posedge clk) begin : scoreboard
    stego_out_t want;
    if (rst) begin
      reg_mode    = 1'b0;
      reg_skip    = SKIP_RESET;
      reg_len     = '0;
      st_pos      = '0;
      st_len_acc  = '0;
      st_byte_acc = '0;
      st_latch    = '0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_MODE:         reg_mode = cfg_data[0];
          CFG_HEADER_SKIP:  reg_skip = cfg_data[15:0];
          CFG_EMBED_LENGTH: reg_len  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        n_req++;
        stego_predict(frame_start, cover_byte, payload_byte);
      end
      if (out_valid && out_ready) begin
        case (kind)
          KIND_COVER:  n_cover++;
          KIND_MSG:    n_msg_bytes++;
          KIND_LENGTH: n_lengths++;
          default: ;
        endcase
        if (pending_out.size() == 0) begin
          n_err++;
          if (n_err <= MAX_REPORTS)
            $display("%0t: unexpected result kind=%0d data=%02h len=%08h last=%0b",
                     $realtime, kind, data_byte, found_length, last_byte);
        end else begin
          want = pending_out.pop_front();
          if (kind !== want.kind || data_byte !== want.data ||
              found_length !== want.length || last_byte !== want.last) begin
            n_err++;
            if (n_err <= MAX_REPORTS)
              $display("%0t: mismatch exp kind=%0d data=%02h len=%08h last=%0b / got kind=%0d data=%02h len=%08h last=%0b",
                       $realtime, want.kind, want.data, want.length, want.last,
                       kind, data_byte, found_length, last_byte);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stall before each result
  initial begin : receiver
    int unsigned stall;
    out_ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = pick_gap(calm_out);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Leaves valid high on return; the caller sends again or drains in the same step.
  task automatic send_item(logic fs, logic [7:0] cov, logic [7:0] pay);
    int unsigned gap;
    gap = pick_gap(calm_in);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    frame_start  <= fs;
    cover_byte   <= cov;
    payload_byte <= pay;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    repeat (SETTLE) @(posedge clk);
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(logic m, logic [15:0] skip, logic [31:0] len);
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_MODE;
    cfg_data     <= 32'(m);
    @(posedge clk);
    cfg_index    <= CFG_HEADER_SKIP;
    cfg_data     <= 32'(skip);
    @(posedge clk);
    cfg_index    <= CFG_EMBED_LENGTH;
    cfg_data     <= len;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Frame laid out for the current skip: header, length bits, message bits, tail.
  task automatic send_frame(logic [31:0] len_val, int unsigned n_msg, int unsigned tail,
                            bit cut);
    int unsigned sk;
    int unsigned total;
    int unsigned p;
    int unsigned d;
    logic [7:0]  b;
    logic [7:0]  msg;
    sk    = reg_skip;
    msg   = 8'd0;
    total = sk + LEN_BITS + 8 * n_msg + tail;
    if (cut) total = $urandom_range(1, total);
    for (p = 0; p < total; p++) begin
      b = 8'($urandom);
      if (p >= sk && p < sk + LEN_BITS) begin
        b[0] = len_val[LEN_BITS-1-(p-sk)];
      end else if (p >= sk + LEN_BITS && p - sk - LEN_BITS < 8 * n_msg) begin
        d = p - sk - LEN_BITS;
        if (d % 8 == 0) msg = 8'($urandom);
        b[0] = msg[7 - d % 8];
      end
      send_item(p == 0, b, 8'($urandom));
    end
  endtask

  task automatic test_reset_state();
    send_frame(32'd2, 2, 3, 1'b0);
    drain();
  endtask

  task automatic test_embed_extremes();
    int unsigned p;
    configure(1'b1, 16'd0, 32'hFFFF_FFFF);
    for (p = 0; p < 48; p++)
      send_item(p == 0, p[0] ? 8'hFF : 8'h00, p[3] ? 8'h00 : 8'hFF);
    drain();
    // zero length: the length field carries zeros and every later byte passes untouched
    configure(1'b1, 16'd0, 32'd0);
    for (p = 0; p < 48; p++)
      send_item(p == 0, p[0] ? 8'h00 : 8'hFF, p[3] ? 8'hFF : 8'h00);
    drain();
  endtask

  task automatic test_extract_length_extremes();
    int unsigned p;
    configure(1'b0, 16'd0, 32'd0);
    for (p = 0; p < 56; p++)
      send_item(p == 0, {7'($urandom), 1'b1}, 8'($urandom));
    drain();
    // zero length reported, then nothing recovered
    for (p = 0; p < 48; p++)
      send_item(p == 0, {7'($urandom), 1'b0}, 8'($urandom));
    drain();
  endtask

  task automatic test_mode_switch();
    int unsigned p;
    configure(1'b1, 16'd3, 32'd2);
    for (p = 0; p < 20; p++) send_item(p == 0, 8'($urandom), 8'($urandom));
    drain();
    configure(1'b0, 16'd3, 32'd2);
    for (p = 0; p < 60; p++) send_item(1'b0, 8'($urandom), 8'($urandom));
    drain();
  endtask

  // largest skip: header bytes give nothing in extract and pass as they are in embed
  task automatic test_max_skip();
    int unsigned p;
    calm_in  = 1'b1;
    calm_out = 1'b1;
    configure(1'b0, 16'hFFFF, 32'd5);
    for (p = 0; p < 24; p++) send_item(p == 0, 8'($urandom), 8'($urandom));
    drain();
    configure(1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    for (p = 0; p < 24; p++) send_item(p == 0, 8'($urandom), 8'($urandom));
    drain();
    calm_in  = 1'b0;
    calm_out = 1'b0;
  endtask

  task automatic test_random_frames();
    int unsigned target;
    int unsigned nf;
    int unsigned n_msg;
    logic [31:0] lv;
    logic [15:0] skip;
    logic        m;
    target = n_req + 850;
    while (n_req < target) begin
      calm_in  = ($urandom_range(0, 4) == 0);
      calm_out = ($urandom_range(0, 4) == 0);
      m        = 1'($urandom_range(0, 1));
      skip     = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(13, 40))
                                             : 16'($urandom_range(0, 12));
      case ($urandom_range(0, 7))
        0:       lv = 32'hFFFF_FFFF;
        1:       lv = $urandom;
        default: lv = $urandom_range(0, 4);
      endcase
      configure(m, skip, lv);
      n_msg = (lv <= 4) ? lv : $urandom_range(0, 3);
      if ($urandom_range(0, 5) == 0) n_msg = $urandom_range(0, 4);
      nf = $urandom_range(1, 3);
      repeat (nf) begin
        send_frame(lv, n_msg, $urandom_range(0, 10), $urandom_range(0, 4) == 0);
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 6))
            send_item($urandom_range(0, 5) == 0, 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 5) == 0) drain();
      end
      drain();
    end
  endtask

  initial begin
    cfg_write_en = 1'b0;
    cfg_index    = CFG_MODE;
    cfg_data     = '0;
    in_valid     = 1'b0;
    frame_start  = 1'b0;
    cover_byte   = '0;
    payload_byte = '0;
    calm_in      = 1'b0;
    calm_out     = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_embed_extremes();
    test_extract_length_extremes();
    test_mode_switch();
    test_max_skip();
    test_random_frames();
    drain();

    $display("%0d cover bytes sent; results: %0d cover, %0d message, %0d length; %0d mismatches",
             n_req, n_cover, n_msg_bytes, n_lengths, n_err);
    $display("Both modes, skip 0 to 65535, lengths 0 to all ones, cut and noisy frames.");
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
